// File: hw/rtl/ssc_pkg.sv
// Shared types and constants of the sine sweep (chirp) generator.
// Register map codes, configuration and sample tag structs, sine table builder.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package ssc_pkg;

	localparam int unsigned STEP_W     = 48;
	localparam int unsigned COUNT_W    = 32;
	localparam int unsigned AMP_W      = 15;
	localparam int unsigned RATIO_FRAC = 46;
	localparam int unsigned REG_IDX_W  = 3;
	localparam int unsigned APB_ADDR_W = 6;
	localparam int unsigned APB_DATA_W = 64;

	// Full-scale amplitude doubles as the divisor of the amplitude scaling.
	localparam logic [AMP_W-1:0]  AMP_FULL  = 15'h7FFF;
	localparam logic [AMP_W-1:0]  AMP_HALF  = 15'h3FFF;
	localparam logic [STEP_W-1:0] RATIO_ONE = 48'h4000_0000_0000;

	// pi in Q30 and one in Q30
	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint          Q30_ONE = 64'sd1073741824;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SWEEP_MODE    = 3'd0,
		REG_START_STEP    = 3'd1,
		REG_STEP_DELTA    = 3'd2,
		REG_SWEEP_RATIO   = 3'd3,
		REG_START_FREQ    = 3'd4,
		REG_FREQ_DELTA    = 3'd5,
		REG_AMPLITUDE     = 3'd6,
		REG_TOTAL_SAMPLES = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic               mode;
		logic [STEP_W-1:0]  start_step;
		logic [STEP_W-1:0]  step_delta;
		logic [STEP_W-1:0]  ratio;
		logic [STEP_W-1:0]  start_freq;
		logic [STEP_W-1:0]  freq_delta;
		logic [AMP_W-1:0]   amplitude;
		logic [COUNT_W-1:0] total;
	} cfg_t;

	// Per-sample fields that ride alongside the sine path
	typedef struct packed {
		logic [STEP_W-1:0]  frequency;
		logic [COUNT_W-1:0] number;
		logic               last;
	} tag_t;

	// Quarter-wave entry: Taylor series to the 11th power in Q30, each term
	// truncated, clamped to [0, 1], then scaled to the peak rounding half up.
	function automatic longint unsigned sine_entry(input longint unsigned x,
			input longint unsigned peak);
		longint unsigned x2;
		longint unsigned term;
		longint          sum;
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		term = ((term * x2) >> 30) / 6;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 20;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 42;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 72;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 110;
		sum  = sum - $signed(term);
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > Q30_ONE) begin
			sum = Q30_ONE;
		end
		return ($unsigned(sum) * peak + (64'd1 << 29)) >> 30;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ssc_regs.sv
// Configuration register file of the sine sweep generator, APB-style port.
// Depends on ssc_pkg for the register map and the cfg_t struct.
`default_nettype none

module ssc_regs
	import ssc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic               mode_q;
	logic [STEP_W-1:0]  start_step_q;
	logic [STEP_W-1:0]  step_delta_q;
	logic [STEP_W-1:0]  ratio_q;
	logic [STEP_W-1:0]  start_freq_q;
	logic [STEP_W-1:0]  freq_delta_q;
	logic [AMP_W-1:0]   amplitude_q;
	logic [COUNT_W-1:0] total_q;
	logic               wr_en;
	reg_idx_t           idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1 -: REG_IDX_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b1;
			start_step_q <= '0;
			step_delta_q <= '0;
			ratio_q      <= RATIO_ONE;
			start_freq_q <= '0;
			freq_delta_q <= '0;
			amplitude_q  <= AMP_FULL;
			total_q      <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_SWEEP_MODE:    mode_q       <= pwdata[0];
				REG_START_STEP:    start_step_q <= pwdata[STEP_W-1:0];
				REG_STEP_DELTA:    step_delta_q <= pwdata[STEP_W-1:0];
				REG_SWEEP_RATIO:   ratio_q      <= pwdata[STEP_W-1:0];
				REG_START_FREQ:    start_freq_q <= pwdata[STEP_W-1:0];
				REG_FREQ_DELTA:    freq_delta_q <= pwdata[STEP_W-1:0];
				REG_AMPLITUDE:     amplitude_q  <= pwdata[AMP_W-1:0];
				REG_TOTAL_SAMPLES: total_q      <= pwdata[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SWEEP_MODE:    prdata = APB_DATA_W'(mode_q);
			REG_START_STEP:    prdata = APB_DATA_W'(start_step_q);
			REG_STEP_DELTA:    prdata = APB_DATA_W'(step_delta_q);
			REG_SWEEP_RATIO:   prdata = APB_DATA_W'(ratio_q);
			REG_START_FREQ:    prdata = APB_DATA_W'(start_freq_q);
			REG_FREQ_DELTA:    prdata = APB_DATA_W'(freq_delta_q);
			REG_AMPLITUDE:     prdata = APB_DATA_W'(amplitude_q);
			REG_TOTAL_SAMPLES: prdata = APB_DATA_W'(total_q);
			default:           prdata = '0;
		endcase
	end

	assign cfg = '{
		mode:       mode_q,
		start_step: start_step_q,
		step_delta: step_delta_q,
		ratio:      ratio_q,
		start_freq: start_freq_q,
		freq_delta: freq_delta_q,
		amplitude:  amplitude_q,
		total:      total_q
	};

endmodule

`default_nettype wire

// File: hw/rtl/ssc_sine_table.sv
// Quarter-wave sine table, constant contents built at elaboration, registered read.
// Depends on ssc_pkg for sine_entry and PI_Q30.
`default_nettype none

module ssc_sine_table
	import ssc_pkg::*;
#(
	parameter int unsigned DEPTH   = 1024,
	parameter int unsigned ENTRY_W = 15
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic [$clog2(DEPTH)-1:0] addr,
	output logic [ENTRY_W-1:0]       data
);

	localparam longint unsigned PEAK = (64'd1 << ENTRY_W) - 64'd1;

	logic [ENTRY_W-1:0] rom [DEPTH];
	logic [ENTRY_W-1:0] rd_q;

	for (genvar g = 0; g < DEPTH; g++) begin : g_entry
		// centre of slot g, in Q30 radians
		localparam longint unsigned X = (PI_Q30 * 64'(2 * g + 1)) / (4 * DEPTH);
		assign rom[g] = ENTRY_W'(sine_entry(X, PEAK));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_q <= rom[addr];
		end
	end

	assign data = rd_q;

endmodule

`default_nettype wire

// File: hw/rtl/ssc_sweep.sv
// Sweep state: phase accumulator, phase step, frequency and sample counter.
// Takes tick transactions and fills stage 1. Depends on ssc_pkg.
`default_nettype none

module ssc_sweep
	import ssc_pkg::*;
#(
	parameter int unsigned PHASE_BITS       = 32,
	parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cfg_t                                cfg,
	input  logic                                tick_valid,
	input  logic                                restart,
	output logic                                tick_stall,
	input  logic                                take,
	output logic                                valid_s1,
	output logic                                neg_s1,
	output logic [$clog2(SINE_TABLE_DEPTH)-1:0] addr_s1,
	output tag_t                                tag_s1
);

	localparam int unsigned ADDR_W = $clog2(SINE_TABLE_DEPTH);

	logic [PHASE_BITS-1:0] phase_q, phase_now, phase_next;
	logic [STEP_W-1:0]     step_q, step_now, step_next;
	logic [STEP_W-1:0]     freq_q, freq_now, freq_next;
	logic [COUNT_W-1:0]    count_q, count_now;
	logic                  running_q, running_now;
	logic                  accept, is_last, advance;
	logic [1:0]            quad;
	logic [ADDR_W-1:0]     slot;

	// Round half up at bit 46 and saturate; partial products no wider than 32x32.
	function automatic logic [STEP_W-1:0] ratio_mul(input logic [STEP_W-1:0] a,
			input logic [STEP_W-1:0] b);
		logic [63:0] p00;
		logic [47:0] p01;
		logic [47:0] p10;
		logic [31:0] p11;
		logic [96:0] sum;
		p00 = a[31:0] * b[31:0];
		p01 = a[31:0] * b[47:32];
		p10 = a[47:32] * b[31:0];
		p11 = a[47:32] * b[47:32];
		sum = {33'd0, p00} + {17'd0, p01, 32'd0} + {17'd0, p10, 32'd0}
			+ {1'd0, p11, 64'd0} + (97'd1 << (RATIO_FRAC - 1));
		if (sum[96:RATIO_FRAC+STEP_W] != '0) begin
			return '1;
		end
		return sum[RATIO_FRAC+STEP_W-1:RATIO_FRAC];
	endfunction

	function automatic logic [STEP_W-1:0] add_sat(input logic [STEP_W-1:0] a,
			input logic [STEP_W-1:0] d);
		logic [STEP_W+1:0] s;
		s = {2'b00, a} + {{2{d[STEP_W-1]}}, d};
		if (s[STEP_W+1]) begin
			return '0;
		end else if (s[STEP_W]) begin
			return '1;
		end
		return s[STEP_W-1:0];
	endfunction

	assign tick_stall = ~take;
	assign accept     = tick_valid & take;

	always_comb begin
		if (restart) begin
			phase_now   = '0;
			step_now    = cfg.start_step;
			freq_now    = cfg.start_freq;
			count_now   = '0;
			running_now = 1'b1;
		end else begin
			phase_now   = phase_q;
			step_now    = step_q;
			freq_now    = freq_q;
			count_now   = count_q;
			running_now = running_q;
		end
	end

	assign is_last    = count_now >= cfg.total;
	assign advance    = running_now & ~is_last;
	assign phase_next = phase_now + step_now[STEP_W-1 -: PHASE_BITS];

	always_comb begin
		if (cfg.mode) begin
			step_next = ratio_mul(step_now, cfg.ratio);
			freq_next = ratio_mul(freq_now, cfg.ratio);
		end else begin
			step_next = add_sat(step_now, cfg.step_delta);
			freq_next = add_sat(freq_now, cfg.freq_delta);
		end
	end

	// quadrant from the top two phase bits; mirror the slot in odd quadrants
	assign quad = phase_now[PHASE_BITS-1 -: 2];
	assign slot = quad[0] ? ~phase_now[PHASE_BITS-3 -: ADDR_W]
		: phase_now[PHASE_BITS-3 -: ADDR_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			step_q    <= '0;
			freq_q    <= '0;
			count_q   <= '0;
			running_q <= 1'b0;
		end else if (accept) begin
			running_q <= advance;
			if (advance) begin
				phase_q <= phase_next;
				step_q  <= step_next;
				freq_q  <= freq_next;
				count_q <= count_now + 1'b1;
			end else begin
				phase_q <= phase_now;
				step_q  <= step_now;
				freq_q  <= freq_now;
				count_q <= count_now;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= accept & running_now;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			neg_s1  <= quad[1];
			addr_s1 <= slot;
			tag_s1  <= '{frequency: freq_now, number: count_now, last: is_last};
		end
	end

	a_last_stops_run: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && running_now && is_last) |=> !running_q)
		else $error("run still active after its last sample");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !restart && advance) |=> (count_q == $past(count_q) + 1'b1))
		else $error("sample counter did not advance by one");

	a_restart_emits_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && restart) |=> (valid_s1 && tag_s1.number == '0))
		else $error("restart did not emit sample zero");

endmodule

`default_nettype wire

// File: hw/rtl/ssc_shaper.sv
// Sine path behind stage 1: table read, amplitude multiply, divide by full scale,
// sign, output register. Depends on ssc_pkg and ssc_sine_table.
`default_nettype none

module ssc_shaper
	import ssc_pkg::*;
#(
	parameter int unsigned SINE_TABLE_DEPTH = 1024,
	parameter int unsigned SAMPLE_BITS      = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [AMP_W-1:0]                    amplitude,
	input  logic                                valid_s1,
	input  logic                                neg_s1,
	input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] addr_s1,
	input  tag_t                                tag_s1,
	output logic                                take,
	output logic                                sample_valid,
	input  logic                                sample_stall,
	output logic signed [SAMPLE_BITS-1:0]       sample_value,
	output tag_t                                sample_tag
);

	localparam int unsigned ENTRY_W = SAMPLE_BITS - 1;
	localparam int unsigned PROD_W  = ENTRY_W + AMP_W;
	localparam int unsigned EST_W   = PROD_W - AMP_W + 1;

	logic                         v_s2, v_s3, v_s4, valid_q;
	logic                         go_s2, go_s3, go_s4, go_out;
	logic                         neg_s2, neg_s3, neg_s4;
	tag_t                         tag_s2, tag_s3, tag_s4, tag_q;
	logic [ENTRY_W-1:0]           entry_s2;
	logic [PROD_W-1:0]            x_s3, x_s4;
	logic [EST_W-1:0]             est_s4;
	logic [PROD_W:0]              est_sum;
	logic [PROD_W-1:0]            rem;
	logic                         bump;
	logic [ENTRY_W-1:0]           mag;
	logic signed [SAMPLE_BITS-1:0] value_q;

	// A stage moves when it is empty or the stage after it moves.
	assign go_out = ~valid_q | ~sample_stall;
	assign go_s4  = ~v_s4 | go_out;
	assign go_s3  = ~v_s3 | go_s4;
	assign go_s2  = ~v_s2 | go_s3;
	assign take   = ~valid_s1 | go_s2;

	ssc_sine_table #(
		.DEPTH   (SINE_TABLE_DEPTH),
		.ENTRY_W (ENTRY_W)
	) u_table (
		.clk  (clk),
		.en   (go_s2),
		.addr (addr_s1),
		.data (entry_s2)
	);

	// Quotient estimate by 1/32767 = 2^-15 + 2^-30 + ..., at most one short.
	assign est_sum = (PROD_W+1)'(x_s3) + (PROD_W+1)'(x_s3 >> AMP_W)
		+ (PROD_W+1)'(x_s3 >> (2 * AMP_W));

	assign rem  = x_s4 - PROD_W'({est_s4, {AMP_W{1'b0}}}) + PROD_W'(est_s4);
	assign bump = rem >= PROD_W'(AMP_FULL);
	assign mag  = ENTRY_W'(est_s4 + EST_W'(bump));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (go_s2) begin
				v_s2 <= valid_s1;
			end
			if (go_s3) begin
				v_s3 <= v_s2;
			end
			if (go_s4) begin
				v_s4 <= v_s3;
			end
			if (go_out) begin
				valid_q <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_s2) begin
			neg_s2 <= neg_s1;
			tag_s2 <= tag_s1;
		end
		if (go_s3) begin
			neg_s3 <= neg_s2;
			tag_s3 <= tag_s2;
			x_s3   <= PROD_W'(entry_s2) * PROD_W'(amplitude) + PROD_W'(AMP_HALF);
		end
		if (go_s4) begin
			neg_s4 <= neg_s3;
			tag_s4 <= tag_s3;
			x_s4   <= x_s3;
			est_s4 <= est_sum[PROD_W:AMP_W];
		end
		if (go_out) begin
			tag_q   <= tag_s4;
			value_q <= neg_s4 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

	assign sample_valid = valid_q;
	assign sample_value = value_q;
	assign sample_tag   = tag_q;

	a_est_one_short: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (rem < (PROD_W'(AMP_FULL) << 1)))
		else $error("quotient estimate off by more than one");

	a_s4_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !go_s4) |=> (v_s4 && $stable(est_s4)))
		else $error("stage 4 lost or changed a held sample");

endmodule

`default_nettype wire

// File: hw/rtl/sine_sweep_chirp_generator_unit.sv
// Top level of the sine sweep (chirp) generator: linear or exponential DDS sweep.
// Depends on ssc_pkg, ssc_regs, ssc_sweep, ssc_shaper (and ssc_sine_table below it).
//
//   channel   direction  handshake                    payload
//   config    in         psel/penable/pwrite, pready  paddr, pwdata (prdata back)
//   tick      in         tick_valid / tick_stall      restart
//   sample    out        sample_valid / sample_stall  sample_value, instant_frequency,
//                                                     sample_number, last_sample
//
// One tick transaction is taken per clock cycle while the sample channel does not
// stall; the rate is set by the sweep state update, which does the step and
// frequency multiply (or saturating add) of one sample combinationally.
// A sample passes from its tick through stage 1, table read, amplitude multiply,
// quotient estimate, then the output register.
// Reset is immediate: the sine table is constant logic, so no fill pass runs.
// A stalled sample holds in the output register while empty stages behind it
// keep taking ticks; up to five samples are in flight.
// Register i sits at byte address 8*i; the sine table depth must be a power of two.
`default_nettype none

module sine_sweep_chirp_generator_unit
	import ssc_pkg::*;
#(
	parameter int unsigned SINE_TABLE_DEPTH = 1024,
	parameter int unsigned PHASE_BITS       = 32,
	parameter int unsigned SAMPLE_BITS      = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [APB_ADDR_W-1:0]         paddr,
	input  logic [APB_DATA_W-1:0]         pwdata,
	output logic [APB_DATA_W-1:0]         prdata,
	output logic                          pready,
	// tick channel
	input  logic                          tick_valid,
	output logic                          tick_stall,
	input  logic                          restart,
	// sample channel
	output logic                          sample_valid,
	input  logic                          sample_stall,
	output logic signed [SAMPLE_BITS-1:0] sample_value,
	output logic [STEP_W-1:0]             instant_frequency,
	output logic [COUNT_W-1:0]            sample_number,
	output logic                          last_sample
);

	localparam int unsigned ADDR_W = $clog2(SINE_TABLE_DEPTH);

	cfg_t              cfg;
	logic              take;
	logic              valid_s1;
	logic              neg_s1;
	logic [ADDR_W-1:0] addr_s1;
	tag_t              tag_s1;
	tag_t              sample_tag;

	// register file; write it only while no sample is in flight
	ssc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sweep recurrence: advance phase, step, frequency and counter per tick
	ssc_sweep #(
		.PHASE_BITS       (PHASE_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_sweep (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.tick_valid (tick_valid),
		.restart    (restart),
		.tick_stall (tick_stall),
		.take       (take),
		.valid_s1   (valid_s1),
		.neg_s1     (neg_s1),
		.addr_s1    (addr_s1),
		.tag_s1     (tag_s1)
	);

	// sine path and output register; drives the back-pressure to the sweep
	ssc_shaper #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.SAMPLE_BITS      (SAMPLE_BITS)
	) u_shaper (
		.clk          (clk),
		.arst_n       (arst_n),
		.amplitude    (cfg.amplitude),
		.valid_s1     (valid_s1),
		.neg_s1       (neg_s1),
		.addr_s1      (addr_s1),
		.tag_s1       (tag_s1),
		.take         (take),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_value (sample_value),
		.sample_tag   (sample_tag)
	);

	// unpack the tag that travelled with the sample
	assign instant_frequency = sample_tag.frequency;
	assign sample_number     = sample_tag.number;
	assign last_sample       = sample_tag.last;

endmodule

`default_nettype wire
